// ----- rtl/wrm_pkg.sv -----
// ----------------------------------------------------------------------------
// wrm_pkg
// Shared types and constants of the windowed rate meter.
// ----------------------------------------------------------------------------
package wrm_pkg;

	localparam int unsigned RATE_W = 48;
	localparam int unsigned WIN_W = 32;
	localparam int unsigned NTHR_W = 5;
	localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};
	localparam logic [18:0] RATE_SCALE = 19'd256000;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_REPORT = 1'b1;

	localparam logic CFG_WINDOW = 1'b0;
	localparam logic CFG_THREADS = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [3:0]  thread_id;
		logic [63:0] sample_count;
		logic [63:0] time_ms;
	} item_t;

	typedef struct packed {
		logic [RATE_W-1:0] current_rate;
		logic              current_valid;
		logic [RATE_W-1:0] average_rate;
		logic              average_valid;
		logic [RATE_W-1:0] highest_rate;
	} result_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_WRITE,
		ST_THREAD,
		ST_WALK_RD,
		ST_WALK_CHK,
		ST_WIN_DIV,
		ST_WIN_WAIT,
		ST_AVG_RD,
		ST_AVG_CHK,
		ST_AVG_DIV,
		ST_AVG_WAIT,
		ST_FINISH,
		ST_EMIT
	} state_t;

	function automatic logic [RATE_W-1:0] sat_add(input logic [RATE_W-1:0] a,
		input logic [RATE_W-1:0] b);
		logic [RATE_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[RATE_W] ? RATE_MAX : s[RATE_W-1:0];
	endfunction

endpackage

// ----- rtl/wrm_fifo.sv -----
// ----------------------------------------------------------------------------
// wrm_fifo
// Small register queue that decouples the front and back of the meter.
// ----------------------------------------------------------------------------
module wrm_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [AW:0]      cnt_q;
	logic             do_push, do_pop;

	assign full = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
		end
	end
endmodule

// ----- rtl/wrm_divider.sv -----
// ----------------------------------------------------------------------------
// wrm_divider
// Bit-serial floor(num * 256000 / den), saturated to 48 bits.
// ----------------------------------------------------------------------------
module wrm_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [63:0]                num,
	input  logic [63:0]                den,
	output logic                       done,
	output logic [wrm_pkg::RATE_W-1:0] quot
);
	logic [82:0] prod_q;
	logic [63:0] den_q, rem_q;
	logic [48:0] q_q;
	logic [6:0]  bit_q;
	logic        busy_q, mul_q, sat_q;
	logic [64:0] r_sh;
	logic        ge;

	assign r_sh = {rem_q, prod_q[bit_q]};
	assign ge = (r_sh >= {1'b0, den_q});
	assign quot = sat_q ? wrm_pkg::RATE_MAX : q_q[47:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			mul_q <= 1'b0;
			done <= 1'b0;
			sat_q <= 1'b0;
			bit_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				mul_q <= 1'b1;
				busy_q <= 1'b0;
				sat_q <= 1'b0;
			end else if (mul_q) begin
				mul_q <= 1'b0;
				busy_q <= 1'b1;
				bit_q <= 7'd82;
			end else if (busy_q) begin
				if (q_q[48] || bit_q == '0) begin
					busy_q <= 1'b0;
					done <= 1'b1;
					sat_q <= q_q[48] || ({q_q[47:0], ge} > {1'b0, wrm_pkg::RATE_MAX});
				end else begin
					bit_q <= bit_q - 1'b1;
				end
			end
		end
	end

	// 256000 = 2^18 - 2^12 - 2^11
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			prod_q <= {19'd0, num};
		end else if (mul_q) begin
			prod_q <= ({19'd0, num} << 18) - ({19'd0, num} << 12) - ({19'd0, num} << 11);
			rem_q <= '0;
			q_q <= '0;
		end else if (busy_q && !q_q[48]) begin
			rem_q <= ge ? 64'(r_sh - {1'b0, den_q}) : r_sh[63:0];
			q_q <= {q_q[47:0], ge};
		end
	end
endmodule

// ----- rtl/wrm_engine.sv -----
// ----------------------------------------------------------------------------
// wrm_engine
// Back end: clears rings after reset, writes samples, walks rings, sums rates and emits reports.
// ----------------------------------------------------------------------------
module wrm_engine #(
	parameter int unsigned MAX_THREADS = 16,
	parameter int unsigned RING_DEPTH = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	input  wrm_pkg::item_t              item,
	output logic                        item_take,
	input  logic [wrm_pkg::WIN_W-1:0]   window_ms,
	input  logic [wrm_pkg::NTHR_W-1:0]  threads,
	output logic                        res_push,
	output wrm_pkg::result_t            res,
	input  logic                        res_full,
	output logic                        clearing
);
	localparam int unsigned TW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
	localparam int unsigned PW = $clog2(RING_DEPTH);
	localparam int unsigned AW = TW + PW;
	localparam int unsigned MEMD = MAX_THREADS * RING_DEPTH;
	localparam int unsigned TCW = TW + 1;

	wrm_pkg::state_t st_q, st_d;

	logic [127:0]  ring_mem [MEMD];
	logic [127:0]  rd_q;
	logic [AW-1:0] raddr, clr_q;
	logic [PW-1:0] wp_q [MAX_THREADS];
	logic [63:0]   fc_q [MAX_THREADS];
	logic [63:0]   ft_q [MAX_THREADS];

	wrm_pkg::item_t cur_q;
	logic [TCW-1:0] t_q, lim;
	logic [TW-1:0]  ti;
	logic [PW-1:0]  step_q;
	logic [63:0]    new_t_q, new_c_q, old_t_q, old_c_q, num_q, den_q;
	logic           new_seen_q, fail_q;
	logic [wrm_pkg::RATE_W-1:0] sum_q, avg_sum_q, hi_q, av_q;
	logic [63:0]    rt, rc;
	logic           div_start, div_done;
	logic [wrm_pkg::RATE_W-1:0] div_q;
	logic           cb, tb;
	logic [63:0]    dc, dt;
	logic           in_range;
	logic [TW-1:0]  sti;

	assign rt = rd_q[127:64];
	assign rc = rd_q[63:0];
	assign lim = (32'(threads) > 32'(MAX_THREADS)) ? TCW'(MAX_THREADS) : TCW'(threads);
	assign ti = t_q[TW-1:0];
	assign sti = cur_q.thread_id[TW-1:0];
	assign in_range = ({28'd0, cur_q.thread_id} < 32'(MAX_THREADS));
	assign cb = new_c_q < rc;
	assign tb = new_t_q < rt;
	assign dc = cb ? rc - new_c_q : new_c_q - rc;
	assign dt = tb ? rt - new_t_q : new_t_q - rt;
	assign clearing = (st_q == wrm_pkg::ST_CLEAR);

	always_comb begin
		raddr = {ti, PW'(wp_q[ti] - step_q)};
	end

	wrm_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(num_q), .den(den_q), .done(div_done), .quot(div_q)
	);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			wrm_pkg::ST_CLEAR:    if (clr_q == AW'(MEMD-1)) st_d = wrm_pkg::ST_IDLE;
			wrm_pkg::ST_IDLE: begin
				if (item_valid) begin
					st_d = (item.cmd == wrm_pkg::CMD_REPORT) ? wrm_pkg::ST_THREAD
						: wrm_pkg::ST_WRITE;
				end
			end
			wrm_pkg::ST_WRITE:    st_d = wrm_pkg::ST_IDLE;
			wrm_pkg::ST_THREAD:
				st_d = (t_q == lim) ? wrm_pkg::ST_AVG_RD : wrm_pkg::ST_WALK_RD;
			wrm_pkg::ST_WALK_RD:  st_d = wrm_pkg::ST_WALK_CHK;
			wrm_pkg::ST_WALK_CHK: begin
				if (rt == '0) begin
					st_d = wrm_pkg::ST_THREAD;
				end else if (new_seen_q && (cur_q.time_ms - rt > {32'd0, window_ms})) begin
					st_d = (new_t_q == rt || (cb != tb && dc != '0)) ? wrm_pkg::ST_THREAD
						: wrm_pkg::ST_WIN_DIV;
				end else if (step_q == PW'(RING_DEPTH-1)) begin
					st_d = wrm_pkg::ST_THREAD;
				end else begin
					st_d = wrm_pkg::ST_WALK_RD;
				end
			end
			wrm_pkg::ST_WIN_DIV:  st_d = wrm_pkg::ST_WIN_WAIT;
			wrm_pkg::ST_WIN_WAIT: if (div_done) st_d = wrm_pkg::ST_THREAD;
			wrm_pkg::ST_AVG_RD:
				st_d = (t_q == lim || fail_q) ? wrm_pkg::ST_FINISH : wrm_pkg::ST_AVG_CHK;
			wrm_pkg::ST_AVG_CHK: begin
				if (ft_q[ti] == '0 || rt == '0 || ft_q[ti] >= rt) st_d = wrm_pkg::ST_FINISH;
				else st_d = wrm_pkg::ST_AVG_DIV;
			end
			wrm_pkg::ST_AVG_DIV:  st_d = wrm_pkg::ST_AVG_WAIT;
			wrm_pkg::ST_AVG_WAIT: if (div_done) st_d = wrm_pkg::ST_AVG_RD;
			wrm_pkg::ST_FINISH:   st_d = wrm_pkg::ST_EMIT;
			wrm_pkg::ST_EMIT:     if (!res_full) st_d = wrm_pkg::ST_IDLE;
			default:              st_d = wrm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		item_take = (st_q == wrm_pkg::ST_IDLE) && item_valid;
		div_start = (st_q == wrm_pkg::ST_WIN_DIV) || (st_q == wrm_pkg::ST_AVG_DIV);
		res_push = (st_q == wrm_pkg::ST_EMIT) && !res_full;
		res.current_rate = sum_q;
		res.current_valid = (sum_q != '0);
		res.average_rate = av_q;
		res.average_valid = (av_q != '0);
		res.highest_rate = hi_q;
	end

	always_ff @(posedge clk) begin
		if (st_q == wrm_pkg::ST_CLEAR) begin
			ring_mem[clr_q] <= '0;
		end else if (st_q == wrm_pkg::ST_WRITE && in_range) begin
			ring_mem[{sti, wp_q[sti]}] <= {cur_q.time_ms, cur_q.sample_count};
		end
		rd_q <= ring_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= wrm_pkg::ST_CLEAR;
			clr_q <= '0;
			hi_q <= '0;
			av_q <= '0;
			for (int i = 0; i < MAX_THREADS; i++) begin
				wp_q[i] <= '0;
				ft_q[i] <= '0;
				fc_q[i] <= '0;
			end
		end else begin
			st_q <= st_d;
			if (st_q == wrm_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (st_q == wrm_pkg::ST_WRITE && in_range) begin
				wp_q[sti] <= wp_q[sti] + 1'b1;
				if (ft_q[sti] == '0 && cur_q.sample_count != '0) begin
					ft_q[sti] <= cur_q.time_ms;
					fc_q[sti] <= cur_q.sample_count;
				end
			end
			if (st_q == wrm_pkg::ST_FINISH) begin
				if (sum_q != '0 && sum_q > hi_q) hi_q <= sum_q;
				if (!fail_q && avg_sum_q != '0) av_q <= avg_sum_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			cur_q <= item;
			t_q <= '0;
			sum_q <= '0;
			avg_sum_q <= '0;
			fail_q <= 1'b0;
		end
		unique case (st_q)
			wrm_pkg::ST_THREAD: begin
				step_q <= PW'(1);
				new_seen_q <= 1'b0;
				if (st_d == wrm_pkg::ST_AVG_RD) begin
					t_q <= '0;
				end
			end
			wrm_pkg::ST_WALK_CHK: begin
				step_q <= step_q + 1'b1;
				if (rt != '0 && !new_seen_q) begin
					new_seen_q <= 1'b1;
					new_t_q <= rt;
					new_c_q <= rc;
				end
				num_q <= dc;
				den_q <= dt;
				if (st_d == wrm_pkg::ST_THREAD) t_q <= t_q + 1'b1;
			end
			wrm_pkg::ST_WIN_WAIT: begin
				if (div_done) begin
					sum_q <= wrm_pkg::sat_add(sum_q, div_q);
					t_q <= t_q + 1'b1;
				end
			end
			wrm_pkg::ST_AVG_CHK: begin
				num_q <= rc - fc_q[ti];
				den_q <= rt - ft_q[ti];
				if (ft_q[ti] == '0 || rt == '0 || ft_q[ti] >= rt) fail_q <= 1'b1;
			end
			wrm_pkg::ST_AVG_WAIT: begin
				if (div_done) begin
					avg_sum_q <= wrm_pkg::sat_add(avg_sum_q, div_q);
					t_q <= t_q + 1'b1;
				end
			end
			default: ;
		endcase
	end
endmodule

// ----- rtl/windowed_rate_meter.sv -----
// ----------------------------------------------------------------------------
// windowed_rate_meter
// Per-thread sample rings with windowed, long-run and peak rate reporting.
// ----------------------------------------------------------------------------
// channel   | handshake      | payload
// input     | push / full    | cmd, thread_id, sample_count, time_ms
// result    | pop / empty    | current_rate, current_valid, average_rate,
//           |                | average_valid, highest_rate
// config    | cfg_we         | cfg_index, cfg_wdata
//
// A sample is written to its ring in the back end. A report walks each active
// ring slot by slot, then runs a serial divide per thread for the window and
// again for the average; the single divider sets the pace. The back end takes
// one item at a time. After reset a clearing pass wipes every ring slot;
// items queue but are not processed meanwhile.
// A full result queue stalls the back end; the input queue then fills.
// ----------------------------------------------------------------------------
module windowed_rate_meter #(
	parameter int unsigned MAX_THREADS = 16,
	parameter int unsigned RING_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        cmd,
	input  logic [3:0]  thread_id,
	input  logic [63:0] sample_count,
	input  logic [63:0] time_ms,
	output logic        empty,
	input  logic        pop,
	output logic [47:0] current_rate,
	output logic        current_valid,
	output logic [47:0] average_rate,
	output logic        average_valid,
	output logic [47:0] highest_rate,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata
);
	localparam int unsigned IW = $bits(wrm_pkg::item_t);
	localparam int unsigned RW = $bits(wrm_pkg::result_t);

	logic [wrm_pkg::WIN_W-1:0]  window_q;
	logic [wrm_pkg::NTHR_W-1:0] threads_q;
	wrm_pkg::item_t   in_item, q_item;
	wrm_pkg::result_t eng_res, out_res;
	logic q_empty, take, res_push, res_full, clearing;

	assign in_item = '{cmd: cmd, thread_id: thread_id,
		sample_count: sample_count, time_ms: time_ms};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= 32'd10000;
			threads_q <= 5'd1;
		end else if (cfg_we) begin
			if (cfg_index == wrm_pkg::CFG_WINDOW) window_q <= cfg_wdata;
			else threads_q <= cfg_wdata[wrm_pkg::NTHR_W-1:0];
		end
	end

	wrm_fifo #(.WIDTH(IW), .DEPTH(4)) u_in_q (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(in_item), .full(full),
		.pop(take), .rdata(q_item), .empty(q_empty)
	);

	wrm_engine #(.MAX_THREADS(MAX_THREADS), .RING_DEPTH(RING_DEPTH)) u_eng (
		.clk(clk), .arst_n(arst_n), .item_valid(!q_empty), .item(q_item),
		.item_take(take), .window_ms(window_q), .threads(threads_q),
		.res_push(res_push), .res(eng_res), .res_full(res_full), .clearing(clearing)
	);

	wrm_fifo #(.WIDTH(RW), .DEPTH(2)) u_out_q (
		.clk(clk), .arst_n(arst_n), .push(res_push), .wdata(eng_res), .full(res_full),
		.pop(pop), .rdata(out_res), .empty(empty)
	);

	assign current_rate = out_res.current_rate;
	assign current_valid = out_res.current_valid;
	assign average_rate = out_res.average_rate;
	assign average_valid = out_res.average_valid;
	assign highest_rate = out_res.highest_rate;

	a_no_take_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !take) else $error("item taken during clear");
	a_valid_flag: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (current_valid == (current_rate != '0))) else $error("valid flag");
	a_highest: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (highest_rate >= current_rate)) else $error("highest below current");
endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for windowed_rate_meter. Samples and reports go in
// through the push/full queue and a predictor keeps its own per-thread rings
// to work out each report. Results are popped under a changing stall pattern
// and compared field by field. Config is changed only while no item is in flight.
// ----------------------------------------------------------------------------
module testbench;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        push;
	logic        full;
	logic        cmd;
	logic [3:0]  thread_id;
	logic [63:0] sample_count;
	logic [63:0] time_ms;
	logic        empty;
	logic        pop;
	logic [47:0] current_rate;
	logic        current_valid;
	logic [47:0] average_rate;
	logic        average_valid;
	logic [47:0] highest_rate;
	logic        cfg_we;
	logic        cfg_index;
	logic [31:0] cfg_wdata;

	windowed_rate_meter dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .cmd(cmd),
		.thread_id(thread_id), .sample_count(sample_count), .time_ms(time_ms),
		.empty(empty), .pop(pop), .current_rate(current_rate),
		.current_valid(current_valid), .average_rate(average_rate),
		.average_valid(average_valid), .highest_rate(highest_rate),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	localparam int NTHR = 16;
	localparam int DEPTH = 1024;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [63:0]       cnt_hist [NTHR][DEPTH];
	logic [63:0]       stamp_hist [NTHR][DEPTH];
	int unsigned       wr_ptr [NTHR];
	logic [63:0]       first_cnt [NTHR];
	logic [63:0]       first_stamp [NTHR];
	logic [wrm_pkg::RATE_W-1:0] peak_rate;
	logic [wrm_pkg::RATE_W-1:0] longrun_rate;
	logic [31:0]       window_len;
	logic [4:0]        thread_cfg;

	wrm_pkg::result_t pending_reports [$];
	int          errors = 0;
	int          items_sent = 0;
	int          reports_seen = 0;
	int          settings_used = 0;
	bit          paced = 1'b0;
	int          burst_left = 0;
	logic        hold_request = 1'b0;
	logic [63:0] now_ms = 64'd1000;
	logic [63:0] work_total [NTHR];

	function automatic logic [wrm_pkg::RATE_W-1:0] scale_rate(logic [63:0] num,
		logic [63:0] den);
		logic [127:0] q;
		q = ({64'd0, num} * 128'd256000) / {64'd0, den};
		return (q > {80'd0, wrm_pkg::RATE_MAX}) ? wrm_pkg::RATE_MAX : q[wrm_pkg::RATE_W-1:0];
	endfunction

	function automatic logic [wrm_pkg::RATE_W-1:0] clamp_sum(logic [wrm_pkg::RATE_W-1:0] a,
		logic [wrm_pkg::RATE_W-1:0] b);
		logic [wrm_pkg::RATE_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[wrm_pkg::RATE_W] ? wrm_pkg::RATE_MAX : s[wrm_pkg::RATE_W-1:0];
	endfunction

	function automatic int thread_span();
		return (thread_cfg > NTHR) ? NTHR : int'(thread_cfg);
	endfunction

	function automatic logic [wrm_pkg::RATE_W-1:0] thread_window_rate(int t,
		logic [63:0] now);
		logic [63:0] nt, nc, ot, oc, st, dc, dt;
		bit          have_old, cb, tb;
		int          idx;
		nt = 0; nc = 0; ot = 0; oc = 0; have_old = 0;
		for (int i = 1; i < DEPTH; i++) begin
			idx = (wr_ptr[t] + DEPTH - i) % DEPTH;
			st = stamp_hist[t][idx];
			if (st == 0)
				break;
			if (nt == 0) begin
				nt = st;
				nc = cnt_hist[t][idx];
			end else if (now - st > {32'd0, window_len}) begin
				ot = st;
				oc = cnt_hist[t][idx];
				have_old = 1;
				break;
			end
		end
		if (!have_old || nt == 0 || nt == ot)
			return '0;
		cb = nc < oc;
		tb = nt < ot;
		dc = cb ? oc - nc : nc - oc;
		dt = tb ? ot - nt : nt - ot;
		if (cb != tb && dc != 0)
			return '0;
		return scale_rate(dc, dt);
	endfunction

	function automatic void refresh_longrun();
		logic [wrm_pkg::RATE_W-1:0] sum;
		logic [63:0]       t1, t2;
		int                idx;
		sum = '0;
		for (int t = 0; t < thread_span(); t++) begin
			idx = (wr_ptr[t] + DEPTH - 1) % DEPTH;
			t1 = first_stamp[t];
			t2 = stamp_hist[t][idx];
			if (t1 == 0 || t2 == 0 || t1 >= t2)
				return;
			sum = clamp_sum(sum, scale_rate(cnt_hist[t][idx] - first_cnt[t], t2 - t1));
		end
		if (sum != 0)
			longrun_rate = sum;
	endfunction

	task automatic predict_item(wrm_pkg::item_t it);
		wrm_pkg::result_t  r;
		logic [wrm_pkg::RATE_W-1:0] sum;
		int                t;
		if (it.cmd == wrm_pkg::CMD_SAMPLE) begin
			t = it.thread_id;
			cnt_hist[t][wr_ptr[t]] = it.sample_count;
			stamp_hist[t][wr_ptr[t]] = it.time_ms;
			if (first_stamp[t] == 0 && it.sample_count > 0) begin
				first_stamp[t] = it.time_ms;
				first_cnt[t] = it.sample_count;
			end
			wr_ptr[t] = (wr_ptr[t] + 1) % DEPTH;
		end else begin
			sum = '0;
			for (int i = 0; i < thread_span(); i++)
				sum = clamp_sum(sum, thread_window_rate(i, it.time_ms));
			if (sum != 0 && sum > peak_rate)
				peak_rate = sum;
			refresh_longrun();
			r.current_rate = sum;
			r.current_valid = sum != 0;
			r.average_rate = longrun_rate;
			r.average_valid = longrun_rate != 0;
			r.highest_rate = peak_rate;
			pending_reports.push_back(r);
		end
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// result checker and receiver stall pattern
	int pop_mode = 0;
	int mode_left = 0;
	int hold_left = 0;
	always @(posedge clk) begin
		wrm_pkg::result_t w;
		if (arst_n && pop && !empty) begin
			reports_seen++;
			if (pending_reports.size() == 0) begin
				report_mismatch("unexpected result", 64'(current_rate), 64'd0);
			end else begin
				w = pending_reports.pop_front();
				if (current_rate !== w.current_rate)
					report_mismatch("current_rate", 64'(current_rate), 64'(w.current_rate));
				if (current_valid !== w.current_valid)
					report_mismatch("current_valid", 64'(current_valid),
						64'(w.current_valid));
				if (average_rate !== w.average_rate)
					report_mismatch("average_rate", 64'(average_rate), 64'(w.average_rate));
				if (average_valid !== w.average_valid)
					report_mismatch("average_valid", 64'(average_valid),
						64'(w.average_valid));
				if (highest_rate !== w.highest_rate)
					report_mismatch("highest_rate", 64'(highest_rate), 64'(w.highest_rate));
			end
		end
		if (hold_request && hold_left == 0) begin
			hold_left = 4000;
			hold_request <= 1'b0;
		end
		if (mode_left == 0) begin
			pop_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(50, 300);
		end
		mode_left--;
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			case (pop_mode)
				0: pop <= 1'b1;
				1: pop <= $urandom_range(0, 1);
				2: pop <= ($urandom_range(0, 3) == 0);
				default: pop <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	task automatic send_item(wrm_pkg::item_t it);
		int gap;
		if (paced) begin
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
				burst_left = $urandom_range(1, 20);
				if (gap > 0) begin
					push <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
		end
		push <= 1'b1;
		cmd <= it.cmd;
		thread_id <= it.thread_id;
		sample_count <= it.sample_count;
		time_ms <= it.time_ms;
		do @(posedge clk); while (full);
		predict_item(it);
		items_sent++;
	endtask

	task automatic sample(int t, logic [63:0] c, logic [63:0] s);
		wrm_pkg::item_t it;
		it = '{cmd: wrm_pkg::CMD_SAMPLE, thread_id: t[3:0], sample_count: c, time_ms: s};
		send_item(it);
	endtask

	task automatic report(logic [63:0] s);
		wrm_pkg::item_t it;
		it = '{cmd: wrm_pkg::CMD_REPORT, thread_id: 4'($urandom),
			sample_count: {$urandom, $urandom}, time_ms: s};
		send_item(it);
	endtask

	task automatic drain();
		push <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic set_config(logic [31:0] win, logic [4:0] thr);
		cfg_we <= 1'b1;
		cfg_index <= wrm_pkg::CFG_WINDOW;
		cfg_wdata <= win;
		@(posedge clk);
		window_len = win;
		cfg_index <= wrm_pkg::CFG_THREADS;
		cfg_wdata <= {27'd0, thr};
		@(posedge clk);
		thread_cfg = thr;
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic test_directed();
		set_config(32'd1000, 5'd4);
		sample(0, 0, 100);
		sample(0, 1000, 200);
		sample(0, 5000, 3000);
		sample(1, 10, 50);
		sample(1, 20, 50);
		sample(2, 1000, 100);
		sample(2, 10, 5000);
		sample(3, 1, 100);
		sample(3, '1, 2101);
		report(3100);
		report(6200);
		sample(0, 7, 0);
		report(6300);
		sample(3, '1, '1);
		report(0);
		report('1);
		drain();
		set_config(32'd1, 5'd0);
		report(7000);
		drain();
		set_config(32'hFFFF_FFFF, 5'd31);
		report(8000);
		drain();
		set_config(32'd1, 5'd16);
		report(9000);
		drain();
	endtask

	task automatic traffic(int n, int thr);
		int t;
		wrm_pkg::item_t it;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 9) == 0) begin
				it.cmd = 1'($urandom);
				it.thread_id = 4'($urandom);
				it.sample_count = {$urandom, $urandom};
				it.time_ms = {$urandom, $urandom};
				if (it.cmd == wrm_pkg::CMD_SAMPLE && it.thread_id >= thr)
					it.thread_id = 4'($urandom_range(0, thr - 1));
				send_item(it);
			end else if ($urandom_range(0, 3) == 0) begin
				report(now_ms + $urandom_range(0, 500));
			end else begin
				t = $urandom_range(0, thr - 1);
				now_ms += $urandom_range(1, 400);
				case ($urandom_range(0, 19))
					0: work_total[t] = work_total[t] - $urandom_range(1, 1000);
					1: work_total[t] = work_total[t] + {$urandom, $urandom};
					default: work_total[t] = work_total[t] + $urandom_range(0, 5000);
				endcase
				sample(t, work_total[t], now_ms);
			end
		end
		drain();
	endtask

	task automatic test_random();
		paced = 1'b1;
		set_config(32'd2000, 5'd3);
		traffic(160, 3);
		set_config(32'd1, 5'd1);
		traffic(120, 1);
		set_config($urandom_range(50, 5000), 5'd16);
		traffic(200, 16);
		set_config(32'hFFFF_FFFF, 5'd8);
		traffic(100, 8);
		paced = 1'b0;
	endtask

	task automatic test_backpressure();
		set_config(32'd500, 5'd2);
		hold_request <= 1'b1;
		for (int k = 0; k < 120; k++) begin
			now_ms += $urandom_range(1, 300);
			if (k % 2 == 0)
				report(now_ms);
			else
				sample(k % 4 == 1 ? 0 : 1, now_ms * 3, now_ms);
		end
		drain();
	endtask

	initial begin
		for (int t = 0; t < NTHR; t++) begin
			for (int i = 0; i < DEPTH; i++) begin
				cnt_hist[t][i] = '0;
				stamp_hist[t][i] = '0;
			end
			wr_ptr[t] = 0;
			first_cnt[t] = '0;
			first_stamp[t] = '0;
			work_total[t] = '0;
		end
		peak_rate = '0;
		longrun_rate = '0;
		window_len = 32'd10000;
		thread_cfg = 5'd1;
		arst_n <= 1'b0;
		push <= 1'b0;
		cmd <= wrm_pkg::CMD_SAMPLE;
		thread_id <= '0;
		sample_count <= '0;
		time_ms <= '0;
		cfg_we <= 1'b0;
		cfg_index <= wrm_pkg::CFG_WINDOW;
		cfg_wdata <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		test_backpressure();
		repeat (200) @(posedge clk);
		$display("covered %0d items, %0d results, %0d config settings",
			items_sent, reports_seen, settings_used);
		if (errors == 0 && pending_reports.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#200000000;
		$display("timeout after %0d items", items_sent);
		$display("FAILED: results differ");
		$finish;
	end

endmodule
